// ===== sv/cmr_pkg.sv =====
`default_nettype none

package cmr_pkg;

   localparam logic [1:0] CMD_CPUID   = 2'd0;
   localparam logic [1:0] CMD_MSR_RD  = 2'd1;
   localparam logic [1:0] CMD_MSR_WR  = 2'd2;
   localparam logic [1:0] CMD_TICK    = 2'd3;

   localparam int unsigned CSR_COUNT = 8;
   localparam int unsigned CSR_AW    = 3;

   localparam logic [CSR_AW-1:0] CSR_BASE_CLK    = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_MAX_MHZ     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_BUS_MHZ     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_XTAL_HZ     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_TSC_NUMER   = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_TSC_DENOM   = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_PHYS_BITS   = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_LINEAR_BITS = 3'd7;

   localparam logic [15:0] RST_BASE_CLK    = 16'd3000;
   localparam logic [15:0] RST_MAX_MHZ     = 16'd5800;
   localparam logic [15:0] RST_BUS_MHZ     = 16'd100;
   localparam logic [31:0] RST_XTAL_HZ     = 32'd38400000;
   localparam logic [31:0] RST_TSC_NUMER   = 32'd156;
   localparam logic [31:0] RST_TSC_DENOM   = 32'd2;
   localparam logic [7:0]  RST_PHYS_BITS   = 8'd46;
   localparam logic [7:0]  RST_LINEAR_BITS = 8'd48;

   // base clock / 10 as (x * 52429) >> 19, exact for 16-bit x
   localparam int unsigned    PERF_STEP_W     = 13;
   localparam int unsigned    PERF_RECIP_SH   = 19;
   localparam logic [31:0]    PERF_RECIP      = 32'd52429;
   localparam logic [PERF_STEP_W-1:0] RST_PERF_STEP = 13'd300;

   localparam logic [31:0] LEAF_THERMAL   = 32'h0000_0006;
   localparam logic [31:0] LEAF_TSC       = 32'h0000_0015;
   localparam logic [31:0] LEAF_FREQ      = 32'h0000_0016;
   localparam logic [31:0] LEAF_ADDR_SIZE = 32'h8000_0008;
   localparam logic [31:0] LEAF_HV_VENDOR = 32'h4000_0000;
   localparam logic [31:0] LEAF_HV_IFACE  = 32'h4000_0001;
   localparam logic [31:0] LEAF_HV_LO     = 32'h4000_0000;
   localparam logic [31:0] LEAF_HV_HI     = 32'h4FFF_FFFF;

   localparam logic [31:0] PWR_MGMT_A     = 32'h0000_0077;
   localparam logic [31:0] PWR_MGMT_B     = 32'h0000_0002;
   localparam logic [31:0] PWR_MGMT_C     = 32'h0000_0009;
   localparam logic [31:0] HV_MAX_LEAF    = 32'h4000_0006;
   localparam logic [31:0] HV_VENDOR_EBX  = 32'h7263_694D;
   localparam logic [31:0] HV_VENDOR_ECX  = 32'h666F_736F;
   localparam logic [31:0] HV_VENDOR_EDX  = 32'h7648_2074;
   localparam logic [31:0] HV_IFACE_SIG   = 32'h3123_7648;

   localparam logic [31:0] MSR_APIC_BASE       = 32'h0000_001B;
   localparam logic [31:0] MSR_FEATURE_CONTROL = 32'h0000_003A;
   localparam logic [31:0] MSR_REF_CYCLES      = 32'h0000_00E7;
   localparam logic [31:0] MSR_ACT_CYCLES      = 32'h0000_00E8;
   localparam logic [31:0] MSR_DBG_CONTROL     = 32'h0000_01D9;
   localparam logic [31:0] MSR_GUEST_OS_ID     = 32'h4000_0000;
   localparam logic [31:0] MSR_HYPERCALL       = 32'h4000_0001;
   localparam logic [31:0] MSR_VP_INDEX        = 32'h4000_0002;
   localparam logic [31:0] MSR_TIME_REF        = 32'h4000_0020;

   localparam logic [63:0] APIC_BASE_VALUE   = 64'h0000_0000_FEE0_0800;
   localparam logic [63:0] APIC_BOOT_CPU_BIT = 64'h0000_0000_0000_0100;
   localparam logic [63:0] DEBUGCTL_MASK     = 64'h0000_0000_0000_FFC3;
   localparam logic [63:0] FC_LOCK_BIT       = 64'h0000_0000_0000_0001;
   localparam logic [63:0] FC_VMX_BIT        = 64'h0000_0000_0000_0004;

   localparam int unsigned MAX_DBG_CPUS = 16;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  cpu_index;
      logic [31:0] index;
      logic [63:0] write_value;
   } req_type;

   typedef struct packed {
      logic        handled;
      logic [31:0] out_a;
      logic [31:0] out_b;
      logic [31:0] out_c;
      logic [31:0] out_d;
   } rsp_type;

   typedef struct packed {
      logic [15:0] base_clock_mhz;
      logic [15:0] max_mhz;
      logic [15:0] bus_mhz;
      logic [31:0] xtal_freq_hz;
      logic [31:0] tsc_numer;
      logic [31:0] tsc_denom;
      logic [7:0]  phys_bits;
      logic [7:0]  linear_bits;
   } cfg_type;

   typedef struct packed {
      logic [63:0] feature_control;
      logic [63:0] guest_os_ident;
      logic [63:0] hypercall_page;
      logic [63:0] time_ref_count;
      logic [63:0] perf_count;
      logic [15:0] debug_control;
   } state_view_type;

   typedef struct packed {
      logic        tick;
      logic        fc_we;
      logic        gos_we;
      logic        hcp_we;
      logic        dbg_we;
      logic [63:0] wdata;
   } state_upd_type;

   function automatic logic in_span(input logic [31:0] id, input logic [31:0] lo,
                                    input logic [31:0] hi);
      return (id >= lo) && (id <= hi);
   endfunction

   function automatic logic msr_vmx_or_trace(input logic [31:0] id);
      return in_span(id, 32'h480, 32'h491) || (id == 32'hC001_0114) ||
             in_span(id, 32'h560, 32'h561) || in_span(id, 32'h570, 32'h572) ||
             in_span(id, 32'h580, 32'h58F);
   endfunction

   function automatic logic msr_present(input logic [31:0] id);
      return in_span(id, 32'h4000_0000, 32'h4000_00FF) ||
             (id == 32'h17) || in_span(id, 32'h34, 32'h35) || (id == 32'h3B) ||
             in_span(id, 32'h48, 32'h4F) || (id == 32'h8B) || (id == 32'hCE) ||
             (id == 32'hE2) || (id == 32'hFE) || in_span(id, 32'hE7, 32'hE8) ||
             in_span(id, 32'h10A, 32'h10B) || in_span(id, 32'h122, 32'h123) ||
             (id == 32'h17D) || in_span(id, 32'h198, 32'h19C) ||
             in_span(id, 32'h1A0, 32'h1A2) || in_span(id, 32'h1B0, 32'h1B1) ||
             (id == 32'h1D9) || in_span(id, 32'h1F2, 32'h1F3) ||
             in_span(id, 32'h280, 32'h2FF) || (id == 32'h345) ||
             in_span(id, 32'h38D, 32'h391) || in_span(id, 32'h3F1, 32'h3F7) ||
             in_span(id, 32'h6E0, 32'h6E1) || in_span(id, 32'hC80, 32'hC82) ||
             in_span(id, 32'hC000_0103, 32'hC000_0104);
   endfunction

endpackage

`default_nettype wire

// ===== sv/cpuid_and_msr_responder_top.sv =====
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  req_data  (cmr_pkg::req_type)
// rsp_      out        rsp_valid / rsp_ready  rsp_data  (cmr_pkg::rsp_type)
// csr_      in         csr_we                 csr_index, csr_wdata
//
// One word a cycle unless the output stalls: a word is registered on entry, then
// decoded and applied to the MSR state when the decode stage advances, and its
// answer lands in the output register with rsp_valid. A tick word gives no answer.
// Reset is synchronous; configuration and MSR state return to defaults at once.
// A stalled output holds the decode stage; ticks drain even while rsp stalls.
`default_nettype none

module cpuid_and_msr_responder_top #(
   parameter int unsigned NUM_CPUS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  var   cmr_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output cmr_pkg::rsp_type             rsp_data,
   input  wire                          csr_we,
   input  wire  [cmr_pkg::CSR_AW-1:0]   csr_index,
   input  wire  [31:0]                  csr_wdata
);

   cmr_pkg::cfg_type                   cfg_ff;
   logic [cmr_pkg::PERF_STEP_W-1:0]    perf_step_ff;
   logic [31:0]                        perf_prod;

   logic                               s1_valid_ff, s1_valid_in;
   cmr_pkg::req_type                   s1_ff;
   logic                               s1_tick, s1_fire;

   logic                               rsp_valid_ff, rsp_valid_in;
   cmr_pkg::rsp_type                   rsp_ff;

   cmr_pkg::rsp_type                   dec_rsp;
   cmr_pkg::state_upd_type             dec_upd;
   cmr_pkg::state_view_type            view;

   assign perf_prod = 32'(csr_wdata[15:0]) * cmr_pkg::PERF_RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_clock_mhz <= cmr_pkg::RST_BASE_CLK;
         cfg_ff.max_mhz        <= cmr_pkg::RST_MAX_MHZ;
         cfg_ff.bus_mhz        <= cmr_pkg::RST_BUS_MHZ;
         cfg_ff.xtal_freq_hz   <= cmr_pkg::RST_XTAL_HZ;
         cfg_ff.tsc_numer      <= cmr_pkg::RST_TSC_NUMER;
         cfg_ff.tsc_denom      <= cmr_pkg::RST_TSC_DENOM;
         cfg_ff.phys_bits      <= cmr_pkg::RST_PHYS_BITS;
         cfg_ff.linear_bits    <= cmr_pkg::RST_LINEAR_BITS;
         perf_step_ff          <= cmr_pkg::RST_PERF_STEP;
      end else if (csr_we) begin
         unique case (csr_index)
            cmr_pkg::CSR_BASE_CLK: begin
               cfg_ff.base_clock_mhz <= csr_wdata[15:0];
               perf_step_ff <= perf_prod[cmr_pkg::PERF_RECIP_SH +: cmr_pkg::PERF_STEP_W];
            end
            cmr_pkg::CSR_MAX_MHZ:     cfg_ff.max_mhz      <= csr_wdata[15:0];
            cmr_pkg::CSR_BUS_MHZ:     cfg_ff.bus_mhz      <= csr_wdata[15:0];
            cmr_pkg::CSR_XTAL_HZ:     cfg_ff.xtal_freq_hz <= csr_wdata;
            cmr_pkg::CSR_TSC_NUMER:   cfg_ff.tsc_numer    <= csr_wdata;
            cmr_pkg::CSR_TSC_DENOM:   cfg_ff.tsc_denom    <= csr_wdata;
            cmr_pkg::CSR_PHYS_BITS:   cfg_ff.phys_bits    <= csr_wdata[7:0];
            cmr_pkg::CSR_LINEAR_BITS: cfg_ff.linear_bits  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // advance the decode stage when its answer has room, or when it is a tick
   assign s1_tick   = (s1_ff.cmd == cmr_pkg::CMD_TICK);
   assign s1_fire   = s1_valid_ff && (s1_tick || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && !s1_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_data;
      end
      if (s1_fire && !s1_tick) begin
         rsp_ff <= dec_rsp;
      end
   end

   cmr_decode u_decode (
      .req  (s1_ff),
      .cfg  (cfg_ff),
      .view (view),
      .rsp  (dec_rsp),
      .upd  (dec_upd)
   );

   cmr_state #(
      .NUM_CPUS (NUM_CPUS)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .cpu_index (s1_ff.cpu_index),
      .perf_step (perf_step_ff),
      .upd       (dec_upd),
      .view      (view)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_tick_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_tick) |=> (rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready)))
      else $error("tick produced a response word");

   a_cmd_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_tick) |=> rsp_valid_ff)
      else $error("request word lost its response");

   a_stall_means_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && !s1_tick && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without cause");

   a_declined_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.handled) |->
         (rsp_ff.out_a == '0 && rsp_ff.out_b == '0 &&
          rsp_ff.out_c == '0 && rsp_ff.out_d == '0))
      else $error("declined response carries data");

endmodule

`default_nettype wire

// ===== sv/cmr_decode.sv =====
`default_nettype none

module cmr_decode (
   input  var cmr_pkg::req_type        req,
   input  var cmr_pkg::cfg_type        cfg,
   input  var cmr_pkg::state_view_type view,
   output cmr_pkg::rsp_type            rsp,
   output cmr_pkg::state_upd_type      upd
);

   always_comb begin
      logic        ok;
      logic [31:0] ra, rb, rc, rd;
      logic [63:0] v;
      ok = 1'b0;
      ra = '0;
      rb = '0;
      rc = '0;
      rd = '0;
      v  = '0;
      upd = '0;
      upd.wdata = req.write_value;
      unique case (req.cmd)
         cmr_pkg::CMD_CPUID: begin
            priority if (req.index == cmr_pkg::LEAF_ADDR_SIZE) begin
               ok = 1'b1;
               ra = {16'b0, cfg.linear_bits, cfg.phys_bits};
            end else if (req.index == cmr_pkg::LEAF_THERMAL) begin
               ok = 1'b1;
               ra = cmr_pkg::PWR_MGMT_A;
               rb = cmr_pkg::PWR_MGMT_B;
               rc = cmr_pkg::PWR_MGMT_C;
            end else if (req.index == cmr_pkg::LEAF_TSC) begin
               ok = 1'b1;
               ra = cfg.tsc_denom;
               rb = cfg.tsc_numer;
               rc = cfg.xtal_freq_hz;
            end else if (req.index == cmr_pkg::LEAF_FREQ) begin
               ok = 1'b1;
               ra = {16'b0, cfg.base_clock_mhz};
               rb = {16'b0, cfg.max_mhz};
               rc = {16'b0, cfg.bus_mhz};
            end else if (cmr_pkg::in_span(req.index, cmr_pkg::LEAF_HV_LO,
                                          cmr_pkg::LEAF_HV_HI)) begin
               ok = 1'b1;
               if (req.index == cmr_pkg::LEAF_HV_VENDOR) begin
                  ra = cmr_pkg::HV_MAX_LEAF;
                  rb = cmr_pkg::HV_VENDOR_EBX;
                  rc = cmr_pkg::HV_VENDOR_ECX;
                  rd = cmr_pkg::HV_VENDOR_EDX;
               end else if (req.index == cmr_pkg::LEAF_HV_IFACE) begin
                  ra = cmr_pkg::HV_IFACE_SIG;
               end
            end else begin
               ok = 1'b0;
            end
         end
         cmr_pkg::CMD_MSR_RD: begin
            priority if (req.index == cmr_pkg::MSR_VP_INDEX) begin
               ok = 1'b1;
               v  = {60'b0, req.cpu_index};
            end else if (req.index == cmr_pkg::MSR_TIME_REF) begin
               ok = 1'b1;
               v  = view.time_ref_count;
            end else if (req.index == cmr_pkg::MSR_REF_CYCLES ||
                         req.index == cmr_pkg::MSR_ACT_CYCLES) begin
               ok = 1'b1;
               v  = view.perf_count;
            end else if (cmr_pkg::msr_vmx_or_trace(req.index)) begin
               ok = 1'b1;
            end else if (req.index == cmr_pkg::MSR_APIC_BASE) begin
               ok = 1'b1;
               v  = cmr_pkg::APIC_BASE_VALUE |
                    ((req.cpu_index == 4'd0) ? cmr_pkg::APIC_BOOT_CPU_BIT : 64'd0);
            end else if (req.index == cmr_pkg::MSR_FEATURE_CONTROL) begin
               ok = 1'b1;
               v  = view.feature_control;
            end else if (req.index == cmr_pkg::MSR_GUEST_OS_ID) begin
               ok = 1'b1;
               v  = view.guest_os_ident;
            end else if (req.index == cmr_pkg::MSR_HYPERCALL) begin
               ok = 1'b1;
               v  = view.hypercall_page;
            end else if (req.index == cmr_pkg::MSR_DBG_CONTROL) begin
               ok = 1'b1;
               v  = {48'b0, view.debug_control};
            end else begin
               ok = cmr_pkg::msr_present(req.index);
            end
            ra = v[31:0];
            rd = v[63:32];
         end
         cmr_pkg::CMD_MSR_WR: begin
            priority if (req.index == cmr_pkg::MSR_DBG_CONTROL) begin
               ok = ~|(req.write_value & ~cmr_pkg::DEBUGCTL_MASK);
               upd.dbg_we = ok;
            end else if (cmr_pkg::msr_vmx_or_trace(req.index)) begin
               ok = 1'b1;
            end else if (req.index == cmr_pkg::MSR_FEATURE_CONTROL) begin
               ok = 1'b1;
               upd.fc_we = 1'b1;
            end else if (req.index == cmr_pkg::MSR_GUEST_OS_ID) begin
               ok = 1'b1;
               upd.gos_we = 1'b1;
            end else if (req.index == cmr_pkg::MSR_HYPERCALL) begin
               ok = 1'b1;
               upd.hcp_we = 1'b1;
            end else begin
               ok = cmr_pkg::msr_present(req.index);
            end
         end
         cmr_pkg::CMD_TICK: begin
            upd.tick = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      rsp.handled = ok;
      rsp.out_a   = ok ? ra : '0;
      rsp.out_b   = ok ? rb : '0;
      rsp.out_c   = ok ? rc : '0;
      rsp.out_d   = ok ? rd : '0;
   end

endmodule

`default_nettype wire

// ===== sv/cmr_state.sv =====
`default_nettype none

module cmr_state #(
   parameter int unsigned NUM_CPUS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   fire,
   input  wire  [3:0]                            cpu_index,
   input  wire  [cmr_pkg::PERF_STEP_W-1:0]       perf_step,
   input  var   cmr_pkg::state_upd_type          upd,
   output cmr_pkg::state_view_type               view
);

   localparam int unsigned DBG_DEPTH =
      (NUM_CPUS < cmr_pkg::MAX_DBG_CPUS) ? NUM_CPUS : cmr_pkg::MAX_DBG_CPUS;
   localparam int unsigned DBG_AW = (DBG_DEPTH > 1) ? $clog2(DBG_DEPTH) : 1;

   logic [63:0] fc_ff, gos_ff, hcp_ff, time_ff, perf_ff;
   logic [15:0] dbg_ff [DBG_DEPTH];
   logic        dbg_hit;
   logic [DBG_AW-1:0] dbg_idx;

   assign dbg_hit = {1'b0, cpu_index} < 5'(DBG_DEPTH);
   assign dbg_idx = (DBG_DEPTH > 1) ? cpu_index[DBG_AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff   <= cmr_pkg::FC_LOCK_BIT;
         gos_ff  <= '0;
         hcp_ff  <= '0;
         time_ff <= '0;
         perf_ff <= '0;
         for (int i = 0; i < DBG_DEPTH; i++) begin
            dbg_ff[i] <= '0;
         end
      end else if (fire) begin
         if (upd.tick) begin
            time_ff <= time_ff + 64'd1;
            perf_ff <= perf_ff + 64'(perf_step);
         end
         if (upd.fc_we) begin
            fc_ff <= (upd.wdata | cmr_pkg::FC_LOCK_BIT) & ~cmr_pkg::FC_VMX_BIT;
         end
         if (upd.gos_we) begin
            gos_ff <= upd.wdata;
         end
         if (upd.hcp_we) begin
            hcp_ff <= upd.wdata;
         end
         if (upd.dbg_we && dbg_hit) begin
            dbg_ff[dbg_idx] <= upd.wdata[15:0];
         end
      end
   end

   always_comb begin
      view.feature_control = fc_ff;
      view.guest_os_ident  = gos_ff;
      view.hypercall_page  = hcp_ff;
      view.time_ref_count  = time_ff;
      view.perf_count      = perf_ff;
      view.debug_control   = dbg_hit ? dbg_ff[dbg_idx] : '0;
   end

endmodule

`default_nettype wire

// ===== test/cmr_tb_pkg.sv =====
package cmr_tb_pkg;

   import cmr_pkg::*;

   localparam logic [31:0] LF_THERMAL   = 32'h0000_0006;
   localparam logic [31:0] LF_TSC       = 32'h0000_0015;
   localparam logic [31:0] LF_FREQ      = 32'h0000_0016;
   localparam logic [31:0] LF_ADDR      = 32'h8000_0008;
   localparam logic [31:0] LF_HV_VENDOR = 32'h4000_0000;
   localparam logic [31:0] LF_HV_IFACE  = 32'h4000_0001;
   localparam logic [31:0] LF_HV_FIRST  = 32'h4000_0000;
   localparam logic [31:0] LF_HV_LAST   = 32'h4FFF_FFFF;

   localparam logic [31:0] ID_APIC_BASE = 32'h0000_001B;
   localparam logic [31:0] ID_FEAT_CTL  = 32'h0000_003A;
   localparam logic [31:0] ID_MPERF     = 32'h0000_00E7;
   localparam logic [31:0] ID_APERF     = 32'h0000_00E8;
   localparam logic [31:0] ID_DBG_CTL   = 32'h0000_01D9;
   localparam logic [31:0] ID_GUEST_OS  = 32'h4000_0000;
   localparam logic [31:0] ID_HCALL     = 32'h4000_0001;
   localparam logic [31:0] ID_VP_INDEX  = 32'h4000_0002;
   localparam logic [31:0] ID_TIME_REF  = 32'h4000_0020;

   localparam logic [63:0] DBG_LEGAL = 64'h0000_0000_0000_FFC3;
   localparam logic [63:0] FC_LOCK   = 64'h1;
   localparam logic [63:0] FC_VMX    = 64'h4;
   localparam logic [63:0] APIC_ADDR = 64'h0000_0000_FEE0_0800;
   localparam logic [63:0] APIC_BOOT = 64'h100;

   // {first, last} of each MSR range that reads as zero and ignores writes
   localparam int N_PASS = 5;
   localparam logic [63:0] PASS_SPANS [N_PASS] = '{
      64'h0000_0480_0000_0491, 64'hC001_0114_C001_0114, 64'h0000_0560_0000_0561,
      64'h0000_0570_0000_0572, 64'h0000_0580_0000_058F
   };

   localparam int N_PRESENT = 25;
   localparam logic [63:0] PRESENT_SPANS [N_PRESENT] = '{
      64'h4000_0000_4000_00FF, 64'h0000_0017_0000_0017, 64'h0000_0034_0000_0035,
      64'h0000_003B_0000_003B, 64'h0000_0048_0000_004F, 64'h0000_008B_0000_008B,
      64'h0000_00CE_0000_00CE, 64'h0000_00E2_0000_00E2, 64'h0000_00FE_0000_00FE,
      64'h0000_00E7_0000_00E8, 64'h0000_010A_0000_010B, 64'h0000_0122_0000_0123,
      64'h0000_017D_0000_017D, 64'h0000_0198_0000_019C, 64'h0000_01A0_0000_01A2,
      64'h0000_01B0_0000_01B1, 64'h0000_01D9_0000_01D9, 64'h0000_01F2_0000_01F3,
      64'h0000_0280_0000_02FF, 64'h0000_0345_0000_0345, 64'h0000_038D_0000_0391,
      64'h0000_03F1_0000_03F7, 64'h0000_06E0_0000_06E1, 64'h0000_0C80_0000_0C82,
      64'hC000_0103_C000_0104
   };

   class answer_board;
      cfg_type     cfg;
      logic [63:0] feat_ctl;
      logic [63:0] guest_id;
      logic [63:0] hcall_page;
      logic [63:0] ref_ticks;
      logic [63:0] perf_ticks;
      logic [15:0] dbg_ctl [16];
      rsp_type     answers_due [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned declined;
      int unsigned ticks;

      function new();
         cfg = '{base_clock_mhz: 16'd3000, max_mhz: 16'd5800, bus_mhz: 16'd100,
                 xtal_freq_hz: 32'd38400000, tsc_numer: 32'd156, tsc_denom: 32'd2,
                 phys_bits: 8'd46, linear_bits: 8'd48};
         feat_ctl   = FC_LOCK;
         guest_id   = '0;
         hcall_page = '0;
         ref_ticks  = '0;
         perf_ticks = '0;
         foreach (dbg_ctl[i]) dbg_ctl[i] = '0;
         mismatches = 0;
         checked    = 0;
         declined   = 0;
         ticks      = 0;
      endfunction

      function void set_reg(logic [CSR_AW-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_BASE_CLK:    cfg.base_clock_mhz = val[15:0];
            CSR_MAX_MHZ:     cfg.max_mhz        = val[15:0];
            CSR_BUS_MHZ:     cfg.bus_mhz        = val[15:0];
            CSR_XTAL_HZ:     cfg.xtal_freq_hz   = val;
            CSR_TSC_NUMER:   cfg.tsc_numer      = val;
            CSR_TSC_DENOM:   cfg.tsc_denom      = val;
            CSR_PHYS_BITS:   cfg.phys_bits      = val[7:0];
            CSR_LINEAR_BITS: cfg.linear_bits    = val[7:0];
            default: ;
         endcase
      endfunction

      function bit known_msr(logic [31:0] id);
         for (int i = 0; i < N_PASS; i++)
            if (id >= PASS_SPANS[i][63:32] && id <= PASS_SPANS[i][31:0]) return 1'b1;
         for (int i = 0; i < N_PRESENT; i++)
            if (id >= PRESENT_SPANS[i][63:32] && id <= PRESENT_SPANS[i][31:0]) return 1'b1;
         return 1'b0;
      endfunction

      function void note_word(req_type w);
         rsp_type     r;
         logic [63:0] v;
         bit          ok;
         r  = '0;
         v  = '0;
         ok = 1'b1;
         case (w.cmd)
            CMD_TICK: begin
               ref_ticks  += 64'd1;
               perf_ticks += 64'(cfg.base_clock_mhz / 16'd10);
               ticks++;
               return;
            end
            CMD_CPUID: begin
               case (w.index)
                  LF_ADDR: r.out_a = {16'h0, cfg.linear_bits, cfg.phys_bits};
                  LF_THERMAL: begin
                     r.out_a = 32'h77;
                     r.out_b = 32'd2;
                     r.out_c = 32'd9;
                  end
                  LF_TSC: begin
                     r.out_a = cfg.tsc_denom;
                     r.out_b = cfg.tsc_numer;
                     r.out_c = cfg.xtal_freq_hz;
                  end
                  LF_FREQ: begin
                     r.out_a = 32'(cfg.base_clock_mhz);
                     r.out_b = 32'(cfg.max_mhz);
                     r.out_c = 32'(cfg.bus_mhz);
                  end
                  LF_HV_VENDOR: begin
                     r.out_a = 32'h4000_0006;
                     r.out_b = 32'h7263_694D;
                     r.out_c = 32'h666F_736F;
                     r.out_d = 32'h7648_2074;
                  end
                  LF_HV_IFACE: r.out_a = 32'h3123_7648;
                  default: ok = (w.index >= LF_HV_FIRST) && (w.index <= LF_HV_LAST);
               endcase
            end
            CMD_MSR_RD: begin
               case (w.index)
                  ID_VP_INDEX:       v = 64'(w.cpu_index);
                  ID_TIME_REF:       v = ref_ticks;
                  ID_MPERF, ID_APERF: v = perf_ticks;
                  ID_APIC_BASE:      v = APIC_ADDR | ((w.cpu_index == 4'd0) ? APIC_BOOT : '0);
                  ID_FEAT_CTL:       v = feat_ctl;
                  ID_GUEST_OS:       v = guest_id;
                  ID_HCALL:          v = hcall_page;
                  ID_DBG_CTL:        v = 64'(dbg_ctl[w.cpu_index]);
                  default:           ok = known_msr(w.index);
               endcase
               r.out_a = v[31:0];
               r.out_d = v[63:32];
            end
            default: begin
               case (w.index)
                  ID_DBG_CTL:
                     if (|(w.write_value & ~DBG_LEGAL)) ok = 1'b0;
                     else dbg_ctl[w.cpu_index] = w.write_value[15:0];
                  ID_FEAT_CTL: feat_ctl   = (w.write_value | FC_LOCK) & ~FC_VMX;
                  ID_GUEST_OS: guest_id   = w.write_value;
                  ID_HCALL:    hcall_page = w.write_value;
                  default:     ok = known_msr(w.index);
               endcase
            end
         endcase
         if (!ok) r = '0;
         r.handled = ok;
         answers_due.push_back(r);
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         checked++;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected answer: h=%0b a=%h b=%h c=%h d=%h",
                        got.handled, got.out_a, got.out_b, got.out_c, got.out_d);
            return;
         end
         want = answers_due.pop_front();
         if (!want.handled) declined++;
         if (got.handled !== want.handled || got.out_a !== want.out_a ||
             got.out_b !== want.out_b || got.out_c !== want.out_c ||
             got.out_d !== want.out_d) begin
            mismatches++;
            if (mismatches <= 10)
               $display("answer %0d: got h=%0b a=%h b=%h c=%h d=%h, want h=%0b a=%h b=%h c=%h d=%h",
                        checked, got.handled, got.out_a, got.out_b, got.out_c, got.out_d,
                        want.handled, want.out_a, want.out_b, want.out_c, want.out_d);
         end
      endfunction
   endclass

endpackage

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cmr_pkg::*;
   import cmr_tb_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_OFF    = 300;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [CSR_AW-1:0]   csr_index;
   logic [31:0]         csr_wdata;

   answer_board         board;
   int                  send_idle = 0;
   int                  rcv_idle = 0;
   bit                  stall_burst = 1'b0;
   int                  quiet = 0;
   int unsigned         accepted = 0;
   int unsigned         settings = 0;

   cpuid_and_msr_responder_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_answer(rsp_data);
         if (req_valid && req_ready) begin
            board.note_word(req_data);
            accepted++;
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
   end

   initial begin
      while (quiet < QUIET_LIMIT) @(posedge clock);
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_burst) begin
            stall_burst = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   function automatic req_type word_of(logic [1:0] c, logic [3:0] cpu, logic [31:0] id,
                                       logic [63:0] v);
      req_type w;
      w.cmd         = c;
      w.cpu_index   = cpu;
      w.index       = id;
      w.write_value = v;
      return w;
   endfunction

   function automatic logic [31:0] draw_index(bit leaf);
      int          sel;
      int          k;
      logic [63:0] span;
      sel = $urandom_range(9);
      if (leaf) begin
         case (sel)
            0, 1, 2, 3:
               case ($urandom_range(5))
                  0: return LF_THERMAL;
                  1: return LF_TSC;
                  2: return LF_FREQ;
                  3: return LF_ADDR;
                  4: return LF_HV_VENDOR;
                  default: return LF_HV_IFACE;
               endcase
            4, 5: return LF_HV_FIRST + 32'($urandom_range(15));
            6:
               case ($urandom_range(3))
                  0: return LF_HV_FIRST - 32'd1;
                  1: return LF_HV_LAST;
                  2: return LF_HV_LAST + 32'd1;
                  default: return LF_HV_FIRST | ($urandom() & 32'h0FFF_FFFF);
               endcase
            default: return $urandom();
         endcase
      end
      case (sel)
         0, 1, 2, 3:
            case ($urandom_range(8))
               0: return ID_APIC_BASE;
               1: return ID_FEAT_CTL;
               2: return ID_MPERF;
               3: return ID_APERF;
               4: return ID_DBG_CTL;
               5: return ID_GUEST_OS;
               6: return ID_HCALL;
               7: return ID_VP_INDEX;
               default: return ID_TIME_REF;
            endcase
         4, 5, 6: begin
            k = $urandom_range(N_PASS + N_PRESENT - 1);
            span = (k < N_PASS) ? PASS_SPANS[k] : PRESENT_SPANS[k - N_PASS];
            case ($urandom_range(3))
               0: return span[63:32];
               1: return span[31:0];
               2: return span[63:32] - 32'd1;
               default: return span[31:0] + 32'd1;
            endcase
         end
         7: return ID_GUEST_OS + 32'($urandom_range(511));
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type draw_word();
      req_type w;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 15) w.cmd = CMD_TICK;
      else if (pick < 40) w.cmd = CMD_CPUID;
      else if (pick < 70) w.cmd = CMD_MSR_RD;
      else w.cmd = CMD_MSR_WR;
      w.cpu_index   = 4'($urandom_range(15));
      w.index       = draw_index(w.cmd == CMD_CPUID);
      w.write_value = {$urandom(), $urandom()};
      if (w.cmd == CMD_MSR_WR && w.index == ID_DBG_CTL && $urandom_range(1) == 1)
         w.write_value &= DBG_LEGAL;
      return w;
   endfunction

   task automatic push_word(req_type w);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.answers_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic apply_settings(logic [31:0] regs [8]);
      for (int i = 0; i < CSR_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_AW'(i);
         csr_wdata <= regs[i];
         @(posedge clock);
         board.set_reg(CSR_AW'(i), regs[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      settings++;
   endtask

   task automatic run_phase(int words, int snd, int rcv, bit squeeze);
      send_idle = snd;
      rcv_idle  = rcv;
      for (int n = 0; n < words; n++) begin
         if (squeeze && n == words / 4) stall_burst = 1'b1;
         push_word(draw_word());
      end
      settle();
   endtask

   initial begin
      req_type     plan [$];
      logic [31:0] regs [8];

      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      plan.push_back(word_of(CMD_CPUID, 4'd0, LF_ADDR, '0));
      plan.push_back(word_of(CMD_CPUID, 4'd1, LF_THERMAL, '0));
      plan.push_back(word_of(CMD_CPUID, 4'd2, LF_TSC, '0));
      plan.push_back(word_of(CMD_CPUID, 4'd3, LF_FREQ, '0));
      plan.push_back(word_of(CMD_CPUID, 4'd4, LF_HV_VENDOR, '0));
      plan.push_back(word_of(CMD_CPUID, 4'd5, LF_HV_IFACE, '0));
      plan.push_back(word_of(CMD_CPUID, 4'd6, LF_HV_FIRST + 32'd5, '0));
      plan.push_back(word_of(CMD_CPUID, 4'd7, LF_HV_LAST + 32'd1, '1));
      plan.push_back(word_of(CMD_TICK, 4'd8, '0, '0));
      plan.push_back(word_of(CMD_TICK, 4'd15, '1, '1));
      plan.push_back(word_of(CMD_MSR_RD, 4'd3, ID_TIME_REF, '0));
      plan.push_back(word_of(CMD_MSR_RD, 4'd0, ID_APERF, '0));
      plan.push_back(word_of(CMD_MSR_RD, 4'd0, ID_APIC_BASE, '0));
      plan.push_back(word_of(CMD_MSR_RD, 4'd15, ID_APIC_BASE, '0));
      plan.push_back(word_of(CMD_MSR_RD, 4'd15, ID_VP_INDEX, '0));
      plan.push_back(word_of(CMD_MSR_WR, 4'd2, ID_FEAT_CTL, '1));
      plan.push_back(word_of(CMD_MSR_RD, 4'd2, ID_FEAT_CTL, '0));
      plan.push_back(word_of(CMD_MSR_WR, 4'd15, ID_DBG_CTL, DBG_LEGAL));
      plan.push_back(word_of(CMD_MSR_WR, 4'd15, ID_DBG_CTL, FC_VMX));
      plan.push_back(word_of(CMD_MSR_RD, 4'd15, ID_DBG_CTL, '0));
      plan.push_back(word_of(CMD_MSR_WR, 4'd9, ID_GUEST_OS, '1));
      plan.push_back(word_of(CMD_MSR_RD, 4'd9, ID_GUEST_OS, '0));
      plan.push_back(word_of(CMD_MSR_WR, 4'd1, '1, '1));
      plan.push_back(word_of(CMD_MSR_RD, 4'd1, PASS_SPANS[1][63:32], '0));
      plan.push_back(word_of(CMD_MSR_RD, 4'd1, '1, '0));
      foreach (plan[i]) push_word(plan[i]);
      settle();

      foreach (regs[i]) regs[i] = '1;
      apply_settings(regs);
      run_phase(345, 22, 61, 1'b0);

      foreach (regs[i]) regs[i] = '0;
      apply_settings(regs);
      run_phase(345, 61, 22, 1'b0);

      foreach (regs[i]) regs[i] = $urandom();
      apply_settings(regs);
      run_phase(345, 0, 0, 1'b1);

      regs = '{32'd3000, 32'd5800, 32'd100, 32'd38400000, 32'd156, 32'd2, 32'd46, 32'd48};
      apply_settings(regs);
      run_phase(345, 0, 0, 1'b0);

      $display("%0d words accepted (%0d ticks) under %0d register settings",
               accepted, board.ticks, settings + 1);
      $display("%0d answers checked, %0d declined, %0d mismatches",
               board.checked, board.declined, board.mismatches);
      if (board.mismatches == 0 && board.answers_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
